// ===== design/dual_ultrasonic_frame_averager_top_defines.svh =====
// assertion macros shared by the checker of the frame averager
// no dependencies; expects clk and arst_n in the scope of use
`ifndef DUAL_ULTRASONIC_FRAME_AVERAGER_TOP_DEFINES_SVH
`define DUAL_ULTRASONIC_FRAME_AVERAGER_TOP_DEFINES_SVH

// consequence holds in the same cycle as the antecedent
`define DUFA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the antecedent
`define DUFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dufa_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, widths and controller/datapath interface types
// no dependencies
package dufa_pkg;

	localparam int DEF_RING_DEPTH = 64;
	localparam int BYTE_W = 8;
	localparam int WIN_W = 7;
	localparam int MM_W = 16;
	localparam int SUM_W = MM_W + WIN_W;
	localparam int DIV_CNT_W = $clog2(SUM_W);
	localparam int OUT_TDATA_W = 40;
	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
	localparam logic [WIN_W-1:0] WIN_RESET = 7'd1;

	typedef struct packed {
		logic take;
		logic load;
		logic rd_issue;
		logic div_step;
		logic out_load;
	} dufa_cmd_t;

	typedef struct packed {
		logic pair_hit;
		logic reads_done;
		logic out_busy;
	} dufa_sts_t;

endpackage

// ===== design/dufa_parser.sv =====
`timescale 1ns / 1ps
// frame parser for one sensor channel: header hunt, hi/lo/check bytes
// uses dufa_pkg
module dufa_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [dufa_pkg::BYTE_W-1:0] data_in,
	output logic                        good,
	output logic [dufa_pkg::MM_W-1:0]   mm
);

	localparam logic [1:0] POS_HUNT = 2'd0;
	localparam logic [1:0] POS_HI   = 2'd1;
	localparam logic [1:0] POS_LO   = 2'd2;
	localparam logic [1:0] POS_CK   = 2'd3;

	logic [1:0]                 pos_q;
	logic [dufa_pkg::MM_W-1:0]  frame_q;
	logic [dufa_pkg::BYTE_W-1:0] ck_exp;

	// header is counted into the check sum
	assign ck_exp = dufa_pkg::HDR_BYTE + frame_q[15:8] + frame_q[7:0];
	assign good = en && (pos_q == POS_CK) && (ck_exp == data_in);
	assign mm = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			frame_q <= '0;
		end else if (en) begin
			unique case (pos_q)
				POS_HUNT: begin
					if (data_in == dufa_pkg::HDR_BYTE) begin
						pos_q <= POS_HI;
						frame_q <= '0;
					end
				end
				POS_HI: begin
					frame_q[15:8] <= data_in;
					pos_q <= POS_LO;
				end
				POS_LO: begin
					frame_q[7:0] <= data_in;
					pos_q <= POS_CK;
				end
				default: begin
					pos_q <= POS_HUNT;
				end
			endcase
		end
	end

endmodule

// ===== design/dufa_datapath.sv =====
`timescale 1ns / 1ps
// datapath: channel parsers, pending values, pair ring, accumulators,
// shift-subtract divider and output register; uses dufa_pkg and dufa_parser
module dufa_datapath #(
	parameter int RING_DEPTH = dufa_pkg::DEF_RING_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dufa_pkg::dufa_cmd_t              cmd,
	output dufa_pkg::dufa_sts_t              sts,
	input  logic                             sensor_id,
	input  logic [dufa_pkg::BYTE_W-1:0]      data_byte,
	input  logic                             cfg_valid,
	input  logic [dufa_pkg::WIN_W-1:0]       cfg_data,
	input  logic                             m_ready,
	output logic                             m_valid,
	output logic [dufa_pkg::OUT_TDATA_W-1:0] m_data
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int FW = $clog2(RING_DEPTH + 1);
	localparam int MW = dufa_pkg::MM_W;
	localparam int SW = dufa_pkg::SUM_W;
	localparam int WW = dufa_pkg::WIN_W;

	logic [2*MW-1:0] ring_mem [RING_DEPTH];

	logic [WW-1:0] win_q;
	logic [MW-1:0] pv0_q, pv1_q;
	logic          pf0_q, pf1_q;
	logic [AW-1:0] wp_q, rp_q;
	logic [FW-1:0] fill_q;
	logic [WW-1:0] left_q;
	logic          rd_vld_s1;
	logic [2*MW-1:0] rd_data_s1;
	logic          out_vld_q;
	logic [dufa_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic [WW-1:0] wdiv_q;
	logic          enough_q;
	logic [SW-1:0] sum0_q, sum1_q;
	logic [WW-1:0] rem0_q, rem1_q;

	logic          good0, good1, good;
	logic [MW-1:0] mm0, mm1, mm;
	logic          other_flag;
	logic [MW-1:0] new_v0, new_v1;
	logic [FW-1:0] fill_nxt;
	logic [AW-1:0] wp_nxt;
	logic [WW-1:0] w_eff, n_nxt;
	logic          enough_nxt;
	logic          rd_fire;
	logic [WW:0]   r0x, r1x, r0n, r1n;
	logic          ge0, ge1;

	dufa_parser u_parser0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (cmd.take && !sensor_id),
		.data_in (data_byte),
		.good    (good0),
		.mm      (mm0)
	);

	dufa_parser u_parser1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (cmd.take && sensor_id),
		.data_in (data_byte),
		.good    (good1),
		.mm      (mm1)
	);

	assign good = sensor_id ? good1 : good0;
	assign mm = sensor_id ? mm1 : mm0;
	assign other_flag = sensor_id ? pf0_q : pf1_q;
	assign new_v0 = (good && !sensor_id) ? mm : pv0_q;
	assign new_v1 = (good && sensor_id) ? mm : pv1_q;

	assign fill_nxt = (fill_q == FW'(RING_DEPTH)) ? fill_q : fill_q + 1'b1;
	assign wp_nxt = (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;

	// window clamped to 1..RING_DEPTH, pair count to the new fill
	always_comb begin
		w_eff = win_q;
		if (win_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(win_q) > RING_DEPTH) begin
			w_eff = WW'(RING_DEPTH);
		end
		if (int'(fill_nxt) < int'(w_eff)) begin
			n_nxt = WW'(fill_nxt);
		end else begin
			n_nxt = w_eff;
		end
	end

	assign enough_nxt = (n_nxt >= (w_eff >> 1));
	assign rd_fire = cmd.rd_issue && (left_q != '0);

	assign sts.pair_hit = good && other_flag;
	assign sts.reads_done = (left_q == '0) && !rd_vld_s1;
	assign sts.out_busy = out_vld_q && !m_ready;

	// one restoring divide step for each sum against the same divisor
	assign r0x = {rem0_q, sum0_q[SW-1]};
	assign r1x = {rem1_q, sum1_q[SW-1]};
	assign ge0 = (r0x >= {1'b0, wdiv_q});
	assign ge1 = (r1x >= {1'b0, wdiv_q});
	assign r0n = ge0 ? (r0x - {1'b0, wdiv_q}) : r0x;
	assign r1n = ge1 ? (r1x - {1'b0, wdiv_q}) : r1x;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ring_mem[wp_q] <= {new_v1, new_v0};
		end
		if (rd_fire) begin
			rd_data_s1 <= ring_mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= dufa_pkg::WIN_RESET;
			pv0_q <= '0;
			pv1_q <= '0;
			pf0_q <= 1'b0;
			pf1_q <= 1'b0;
			wp_q <= '0;
			rp_q <= '0;
			fill_q <= '0;
			left_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				win_q <= cfg_data;
			end
			if (good) begin
				if (sensor_id) begin
					pv1_q <= mm;
					pf1_q <= 1'b1;
				end else begin
					pv0_q <= mm;
					pf0_q <= 1'b1;
				end
			end
			if (cmd.load) begin
				pf0_q <= 1'b0;
				pf1_q <= 1'b0;
				wp_q <= wp_nxt;
				fill_q <= fill_nxt;
				rp_q <= wp_q;
				left_q <= n_nxt;
			end else if (rd_fire) begin
				rp_q <= (rp_q == '0) ? AW'(RING_DEPTH - 1) : rp_q - 1'b1;
				left_q <= left_q - 1'b1;
			end
			rd_vld_s1 <= rd_fire;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum0_q <= '0;
			sum1_q <= '0;
			rem0_q <= '0;
			rem1_q <= '0;
			wdiv_q <= w_eff;
			enough_q <= enough_nxt;
		end else if (rd_vld_s1) begin
			sum0_q <= sum0_q + SW'(rd_data_s1[MW-1:0]);
			sum1_q <= sum1_q + SW'(rd_data_s1[2*MW-1:MW]);
		end else if (cmd.div_step) begin
			rem0_q <= r0n[WW-1:0];
			rem1_q <= r1n[WW-1:0];
			sum0_q <= {sum0_q[SW-2:0], ge0};
			sum1_q <= {sum1_q[SW-2:0], ge1};
		end
		if (cmd.out_load) begin
			out_data_q <= {7'b0, enough_q,
				(enough_q ? sum1_q[MW-1:0] : {MW{1'b0}}),
				(enough_q ? sum0_q[MW-1:0] : {MW{1'b0}})};
		end
	end

	assign m_valid = out_vld_q;
	assign m_data = out_data_q;

endmodule

// ===== design/dufa_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences byte intake, ring summing, division and output load
// uses dufa_pkg
module dufa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	output logic                s_ready,
	output dufa_pkg::dufa_cmd_t cmd,
	input  dufa_pkg::dufa_sts_t sts
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                       state_q, state_nxt;
	logic [dufa_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic                             take;

	assign s_ready = (state_q == ST_IDLE);
	assign take = s_valid && s_ready;

	always_comb begin
		cmd = '0;
		cmd.take = take;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && sts.pair_hit) begin
					cmd.load = 1'b1;
					state_nxt = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.rd_issue = 1'b1;
				if (sts.reads_done) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == dufa_pkg::DIV_CNT_W'(dufa_pkg::SUM_W - 1)) begin
					state_nxt = ST_OUT;
				end
			end
			default: begin
				// hold the result until the output register is free
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

endmodule

// ===== design/dual_ultrasonic_frame_averager_top.sv =====
`timescale 1ns / 1ps
// Dual ultrasonic frame averager. Each input request carries one serial byte
// and its sensor channel; each channel parses 0xFF/hi/lo/check frames on its
// own. When both channels hold a fresh distance, the pair enters a ring of
// RING_DEPTH entries, the newest n = min(fill, window) pairs are summed and
// divided by the window, and one result request is sent (zeros with
// enough_pairs low when n is below half the window). A byte that does not
// complete a pair leaves the block ready for the next byte. A byte that
// completes a pair is written to the ring; while the output register is free,
// it is followed by n reads from the single read port of the ring memory,
// the add of the registered last read, 23 steps of the bit-serial divider and
// the load of the output register; a stalled result still in the output
// register adds its stall. avg_window may be written only while idle.
// depends on dufa_pkg, dufa_ctrl, dufa_datapath
module dual_ultrasonic_frame_averager_top #(
	parameter int RING_DEPTH = dufa_pkg::DEF_RING_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [dufa_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
	input  logic                             s_axis_tuser,   // [0] sensor_id
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [15:0] first_avg_mm, [31:16] second_avg_mm, [32] enough_pairs, [39:33] zero
	output logic [dufa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dufa_pkg::WIN_W-1:0]       cfg_data        // avg_window
);

	dufa_pkg::dufa_cmd_t cmd;
	dufa_pkg::dufa_sts_t sts;

	assign cfg_ready = 1'b1;

	dufa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	dufa_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.sensor_id (s_axis_tuser),
		.data_byte (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_ready   (m_axis_tready),
		.m_valid   (m_axis_tvalid),
		.m_data    (m_axis_tdata)
	);

endmodule

// ===== design/dufa_checker.sv =====
`timescale 1ns / 1ps
// port-level checks on the frame averager, bound to the top level
// uses dufa_pkg and dual_ultrasonic_frame_averager_top_defines.svh
`include "dual_ultrasonic_frame_averager_top_defines.svh"

module dufa_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [dufa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result keeps its value
	`DUFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// too few pairs means both averages read zero
	`DUFA_ASSERT_SAME(a_short_zero, m_axis_tvalid && !m_axis_tdata[32], m_axis_tdata[31:0] == 32'd0, "averages not zero with too few pairs")

	`DUFA_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0, "padding bits not zero")

	// a new result only appears after the input was held off for the calculation
	`DUFA_ASSERT_SAME(a_rise_busy, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without a calculation phase")

endmodule

bind dual_ultrasonic_frame_averager_top dufa_checker u_dufa_checker (.*);
